### rtl/core/rmq_pkg.sv
// Package for the rotation-matrix-to-quaternion pipeline.
// Holds the fixed-point format, the derived datapath widths, the stage map and the stage record.
// No dependencies.
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int FIELD_W   = 16;
	localparam int N_ROT     = 9;
	localparam int N_QUAT    = 4;
	localparam int IN_W      = N_ROT * FIELD_W;
	localparam int OUT_W     = N_QUAT * FIELD_W;

	// one plus trace, signed
	localparam int TRACE_W = FIELD_W + 2;
	localparam int UW      = ((FRAC_BITS + 1 > TRACE_W) ? FRAC_BITS + 1 : TRACE_W) + 1;
	// radicand, root and partial remainder of the square root
	localparam int NW  = UW - 1 + FRAC_BITS - 2;
	localparam int RW  = (NW + 1) / 2;
	localparam int NP  = 2 * RW;
	localparam int SRW = RW + 3;
	// antisymmetric differences and the divider
	localparam int DW   = FIELD_W + 1;
	localparam int MAGW = DW;
	localparam int NUMW = ((MAGW + FRAC_BITS > RW + 1) ? MAGW + FRAC_BITS : RW + 1) + 1;
	localparam int DRW  = RW + 3;

	// stage map: trace, root digits, divider setup, quotient bits, output format
	localparam int ST_PREP = RW + 1;
	localparam int ST_OUT  = RW + NUMW + 2;
	localparam int N_STG   = ST_OUT + 1;

	localparam int ONE_Q   = 1 << FRAC_BITS;
	localparam int SAT_POS = 32767;
	localparam int SAT_NEG = 32768;

	typedef struct packed {
		logic                       bad;
		logic [NP-1:0]              nsq;
		logic [SRW-1:0]             srem;
		logic [RW-1:0]              root;
		logic [2:0][DW-1:0]         dif;
		logic [2:0][DRW-1:0]        drem;
		logic [2:0][NUMW-1:0]       dnum;
		logic [N_QUAT-1:0][FIELD_W-1:0] quat;
	} pipe_t;

endpackage

### rtl/core/rotation_matrix_to_quaternion.sv
// Rotation matrix to quaternion by the trace method, as one deep pipeline.
// Depends on rmq_pkg for widths, the stage map and the stage record.
//
// Takes one matrix per clock and returns one quaternion per clock while the output is not
// stalled. Its stages, in order: one stage forms the trace and differences, one stage per
// root bit runs the restoring square root, one stage sets up the three dividers, one stage per
// quotient bit runs the three restoring dividers side by side, and one stage saturates, applies
// the sign and packs. The whole pipe advances whenever its last stage is empty or being taken, so a
// stall at the output holds every item in place. bad_trace (m_tuser) is set with all-zero data
// when one plus the trace is not positive.
module rotation_matrix_to_quaternion (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22 from bit 0 up
	input  logic [rmq_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// quat_w, quat_x, quat_y, quat_z from bit 0 up
	output logic [rmq_pkg::OUT_W-1:0]  m_tdata,
	// bad_trace
	output logic                       m_tuser
);
	import rmq_pkg::*;

	pipe_t st_s [N_STG];
	pipe_t nx    [N_STG];
	logic [N_STG-1:0] vld_s;
	logic adv;

	assign adv      = !vld_s[N_STG-1] || m_tready;
	assign s_tready = adv;

	for (genvar g = 0; g < N_STG; g++) begin : g_stg
		if (g == 0) begin : g_in
			logic signed [FIELD_W-1:0] m [N_ROT];
			logic signed [UW-1:0] u;
			always_comb begin
				for (int i = 0; i < N_ROT; i++) begin
					m[i] = $signed(s_tdata[i*FIELD_W +: FIELD_W]);
				end
				nx[g] = '0;
				u = UW'(ONE_Q) + UW'(m[0]) + UW'(m[4]) + UW'(m[8]);
				nx[g].bad = (u <= 0);
				nx[g].nsq = NP'(u[UW-2:0]) << (FRAC_BITS - 2);
				nx[g].dif[0] = DW'(DW'(m[7]) - DW'(m[5]));
				nx[g].dif[1] = DW'(DW'(m[2]) - DW'(m[6]));
				nx[g].dif[2] = DW'(DW'(m[3]) - DW'(m[1]));
			end
		end else if (g < ST_PREP) begin : g_sqrt
			logic [SRW-1:0] sh, trial;
			always_comb begin
				nx[g] = st_s[g-1];
				sh    = {st_s[g-1].srem[SRW-3:0], st_s[g-1].nsq[NP-1 -: 2]};
				trial = SRW'({st_s[g-1].root, 2'b01});
				nx[g].nsq = st_s[g-1].nsq << 2;
				if (sh >= trial) begin
					nx[g].srem = sh - trial;
					nx[g].root = {st_s[g-1].root[RW-2:0], 1'b1};
				end else begin
					nx[g].srem = sh;
					nx[g].root = {st_s[g-1].root[RW-2:0], 1'b0};
				end
			end
		end else if (g == ST_PREP) begin : g_prep
			logic [MAGW-1:0] mag [3];
			always_comb begin
				nx[g] = st_s[g-1];
				nx[g].bad = st_s[g-1].bad || (st_s[g-1].root == '0);
				// the rounding offset is half of 4W
				for (int k = 0; k < 3; k++) begin
					mag[k] = st_s[g-1].dif[k][DW-1] ? MAGW'(-$signed(st_s[g-1].dif[k]))
						: MAGW'(st_s[g-1].dif[k]);
					nx[g].dnum[k] = (NUMW'(mag[k]) << FRAC_BITS)
						+ NUMW'({st_s[g-1].root, 1'b0});
					nx[g].drem[k] = '0;
				end
				if (32'(st_s[g-1].root) > 32'(SAT_POS)) begin
					nx[g].quat[0] = FIELD_W'(SAT_POS);
				end else begin
					nx[g].quat[0] = FIELD_W'(st_s[g-1].root);
				end
			end
		end else if (g < ST_OUT) begin : g_div
			logic [DRW-1:0] sh [3];
			logic [DRW-1:0] den;
			always_comb begin
				nx[g] = st_s[g-1];
				den   = DRW'({st_s[g-1].root, 2'b00});
				for (int k = 0; k < 3; k++) begin
					sh[k] = {st_s[g-1].drem[k][DRW-2:0], st_s[g-1].dnum[k][NUMW-1]};
					if (sh[k] >= den) begin
						nx[g].drem[k] = sh[k] - den;
						nx[g].dnum[k] = {st_s[g-1].dnum[k][NUMW-2:0], 1'b1};
					end else begin
						nx[g].drem[k] = sh[k];
						nx[g].dnum[k] = {st_s[g-1].dnum[k][NUMW-2:0], 1'b0};
					end
				end
			end
		end else begin : g_out
			always_comb begin
				nx[g] = st_s[g-1];
				for (int k = 0; k < 3; k++) begin
					if (!st_s[g-1].dif[k][DW-1]) begin
						nx[g].quat[k+1] = (st_s[g-1].dnum[k] > NUMW'(SAT_POS))
							? FIELD_W'(SAT_POS) : st_s[g-1].dnum[k][FIELD_W-1:0];
					end else begin
						nx[g].quat[k+1] = (st_s[g-1].dnum[k] > NUMW'(SAT_NEG))
							? FIELD_W'(SAT_NEG)
							: FIELD_W'(~st_s[g-1].dnum[k][FIELD_W-1:0] + 1'b1);
					end
				end
				// drop the quaternion on a bad trace
				if (st_s[g-1].bad) begin
					nx[g].quat = '0;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (adv) begin
				vld_s[g] <= (g == 0) ? s_tvalid : vld_s[(g == 0) ? 0 : g-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				st_s[g] <= nx[g];
			end
		end
	end

	assign m_tvalid = vld_s[N_STG-1];
	assign m_tdata  = st_s[N_STG-1].quat;
	assign m_tuser  = st_s[N_STG-1].bad;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("bad trace item carries nonzero quaternion");

	a_w_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[FIELD_W-1:0] != '0)
		else $error("good item with zero scalar part");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> vld_s == $past(vld_s))
		else $error("pipeline moved during stall");

endmodule
